// ===== rtl/alarm_annunciator_with_delay_and_silence_core_assert.svh =====
// ----------------------------------------------------------------------------
// Alarm annunciator assertion macros
// Shorthands for clocked assertions that share clk and arst_n of the scope.
// ----------------------------------------------------------------------------
`ifndef ALARM_ANNUNCIATOR_WITH_DELAY_AND_SILENCE_CORE_ASSERT_SVH
`define ALARM_ANNUNCIATOR_WITH_DELAY_AND_SILENCE_CORE_ASSERT_SVH

// Condition must hold in the same cycle as the trigger.
`define AADS_ASSERT_NOW(lbl, ant, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ant) |-> (cons)) \
		else $error(msg);

// Condition must hold in the cycle after the trigger.
`define AADS_ASSERT_NEXT(lbl, ant, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ant) |=> (cons)) \
		else $error(msg);

`endif

// ===== rtl/aads_pkg.sv =====
// ----------------------------------------------------------------------------
// aads_pkg
// Shared types, codes and defaults of the alarm annunciator.
// ----------------------------------------------------------------------------
`default_nettype none

package aads_pkg;

	localparam int CMD_W  = 2;
	localparam int CAT_W  = 8;
	localparam int KIND_W = 2;
	localparam int REG_W  = 24;
	localparam int IDX_W  = 2;

	localparam int TIME_WIDTH_DEFAULT = 24;
	localparam int QUEUE_DEPTH        = 2;

	// Command codes on the input channel
	localparam logic [CMD_W-1:0] CMD_TICK    = 2'd0;
	localparam logic [CMD_W-1:0] CMD_UPDATE  = 2'd1;
	localparam logic [CMD_W-1:0] CMD_SILENCE = 2'd2;

	// Level categories
	localparam logic [CAT_W-1:0] CAT_NORMAL   = 8'd0;
	localparam logic [CAT_W-1:0] CAT_WARNING  = 8'd1;
	localparam logic [CAT_W-1:0] CAT_CRITICAL = 8'd2;

	// Recorded alarm kinds
	localparam logic [KIND_W-1:0] KIND_NONE     = 2'd0;
	localparam logic [KIND_W-1:0] KIND_WARNING  = 2'd1;
	localparam logic [KIND_W-1:0] KIND_CRITICAL = 2'd2;

	// Configuration register indexes
	localparam logic [IDX_W-1:0] REG_WARNING_DELAY  = 2'd0;
	localparam logic [IDX_W-1:0] REG_CRITICAL_TOGGLE = 2'd1;
	localparam logic [IDX_W-1:0] REG_WARNING_TOGGLE = 2'd2;

	localparam logic [REG_W-1:0] WARNING_DELAY_RST   = 24'd5000;
	localparam logic [REG_W-1:0] CRITICAL_TOGGLE_RST = 24'd250;
	localparam logic [REG_W-1:0] WARNING_TOGGLE_RST  = 24'd500;

	typedef enum logic [1:0] {
		OP_TICK,
		OP_UPDATE,
		OP_SILENCE,
		OP_NONE
	} op_kind_t;

	// Classified item handed from front to back
	typedef struct packed {
		op_kind_t          kind;
		logic [CAT_W-1:0]  category;
		logic              cat_warn;
		logic              cat_crit;
		logic              cat_nonzero;
		logic [KIND_W-1:0] kind_code;
	} op_t;

endpackage

`default_nettype wire

// ===== rtl/aads_cmd_if.sv =====
// ----------------------------------------------------------------------------
// aads_cmd_if
// Command channel: valid/ready with command and category.
// ----------------------------------------------------------------------------
`default_nettype none

interface aads_cmd_if;
	logic                       valid;
	logic                       ready;
	logic [aads_pkg::CMD_W-1:0] command;
	logic [aads_pkg::CAT_W-1:0] category;

	modport source (output valid, command, category, input ready);
	modport sink (input valid, command, category, output ready);
endinterface

`default_nettype wire

// ===== rtl/aads_res_if.sv =====
// ----------------------------------------------------------------------------
// aads_res_if
// Result channel: valid/ready with buzzer and alarm status.
// ----------------------------------------------------------------------------
`default_nettype none

interface aads_res_if;
	logic                        valid;
	logic                        ready;
	logic                        buzzer_on;
	logic                        alarm_active;
	logic                        is_silenced;
	logic [aads_pkg::KIND_W-1:0] alarm_kind;

	modport source (output valid, buzzer_on, alarm_active, is_silenced, alarm_kind,
		input ready);
	modport sink (input valid, buzzer_on, alarm_active, is_silenced, alarm_kind,
		output ready);
endinterface

`default_nettype wire

// ===== rtl/alarm_annunciator_with_delay_and_silence_core.sv =====
// Alarm annunciator with warning delay, user silence and toggling buzzer.
//
// Channels: cmd takes one beat per command (tick, level update with a
// category, user silence); res returns exactly one status beat per command,
// in order: buzzer level, alarm raised, silenced, recorded kind.
// Configuration: cfg_wr_en/cfg_index/cfg_wdata write the warning delay and
// the two toggle intervals; write only while no command is in flight.
// Path: a command passes the decode register, a queue slot and the
// state/result register before its result beat shows up. Throughput: one
// command per cycle while res is not held off; the state update is
// combinational saturating increments and one compare in the back end.
// Reset (arst_n low): alarm, silence, buzzer and counters clear, registers
// return to 5000 / 250 / 500 ms, both channels go empty.
// Stall: while res is held off the result beat stays put, the queue fills
// and then cmd ready drops; nothing is lost or repeated.
// ----------------------------------------------------------------------------
// alarm_annunciator_with_delay_and_silence_core
// Top level: decode front, item queue and execution back end.
// ----------------------------------------------------------------------------
`default_nettype none

module alarm_annunciator_with_delay_and_silence_core #(
	parameter int TIME_WIDTH = aads_pkg::TIME_WIDTH_DEFAULT
) (
	input  wire                       clk,
	input  wire                       arst_n,
	aads_cmd_if.sink                  cmd,
	aads_res_if.source                res,
	input  wire                       cfg_wr_en,
	input  wire [aads_pkg::IDX_W-1:0] cfg_index,
	input  wire [aads_pkg::REG_W-1:0] cfg_wdata
);

	logic          f_valid, f_ready;
	aads_pkg::op_t f_op;
	logic          b_valid, b_ready;
	aads_pkg::op_t b_op;

	aads_front u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (cmd.valid),
		.in_ready    (cmd.ready),
		.in_command  (cmd.command),
		.in_category (cmd.category),
		.op_valid    (f_valid),
		.op_ready    (f_ready),
		.op          (f_op)
	);

	aads_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (f_valid),
		.in_ready  (f_ready),
		.in_op     (f_op),
		.out_valid (b_valid),
		.out_ready (b_ready),
		.out_op    (b_op)
	);

	aads_back #(
		.TIME_WIDTH (TIME_WIDTH)
	) u_back (
		.clk              (clk),
		.arst_n           (arst_n),
		.op_valid         (b_valid),
		.op_ready         (b_ready),
		.op               (b_op),
		.cfg_wr_en        (cfg_wr_en),
		.cfg_index        (cfg_index),
		.cfg_wdata        (cfg_wdata),
		.res_valid        (res.valid),
		.res_ready        (res.ready),
		.res_buzzer_on    (res.buzzer_on),
		.res_alarm_active (res.alarm_active),
		.res_is_silenced  (res.is_silenced),
		.res_alarm_kind   (res.alarm_kind)
	);

endmodule

`default_nettype wire

// ===== rtl/aads_front.sv =====
// ----------------------------------------------------------------------------
// aads_front
// Accepts command beats, decodes them and registers the classified item.
// ----------------------------------------------------------------------------
`default_nettype none

module aads_front (
	input  wire                        clk,
	input  wire                        arst_n,
	input  wire                        in_valid,
	output logic                       in_ready,
	input  wire [aads_pkg::CMD_W-1:0]  in_command,
	input  wire [aads_pkg::CAT_W-1:0]  in_category,
	output logic                       op_valid,
	input  wire                        op_ready,
	output aads_pkg::op_t              op
);

	logic          valid_s1;
	aads_pkg::op_t op_s1;
	aads_pkg::op_t op_dec;
	logic          accept;

	always_comb begin
		op_dec.category    = in_category;
		op_dec.cat_warn    = (in_category == aads_pkg::CAT_WARNING);
		op_dec.cat_crit    = (in_category == aads_pkg::CAT_CRITICAL);
		op_dec.cat_nonzero = (in_category != aads_pkg::CAT_NORMAL);
		priority if (op_dec.cat_crit) begin
			op_dec.kind_code = aads_pkg::KIND_CRITICAL;
		end else if (op_dec.cat_warn) begin
			op_dec.kind_code = aads_pkg::KIND_WARNING;
		end else begin
			op_dec.kind_code = aads_pkg::KIND_NONE;
		end
		unique case (in_command)
			aads_pkg::CMD_TICK:    op_dec.kind = aads_pkg::OP_TICK;
			aads_pkg::CMD_UPDATE:  op_dec.kind = aads_pkg::OP_UPDATE;
			aads_pkg::CMD_SILENCE: op_dec.kind = aads_pkg::OP_SILENCE;
			default:               op_dec.kind = aads_pkg::OP_NONE;
		endcase
	end

	assign in_ready = !valid_s1 || op_ready;
	assign accept   = in_valid && in_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else begin
			valid_s1 <= accept || (valid_s1 && !op_ready);
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			op_s1 <= op_dec;
		end
	end

	assign op_valid = valid_s1;
	assign op       = op_s1;

endmodule

`default_nettype wire

// ===== rtl/aads_queue.sv =====
// ----------------------------------------------------------------------------
// aads_queue
// Short FIFO of classified items between front and back.
// ----------------------------------------------------------------------------
`default_nettype none

module aads_queue (
	input  wire           clk,
	input  wire           arst_n,
	input  wire           in_valid,
	output logic          in_ready,
	input  aads_pkg::op_t in_op,
	output logic          out_valid,
	input  wire           out_ready,
	output aads_pkg::op_t out_op
);

	localparam int DEPTH   = aads_pkg::QUEUE_DEPTH;
	localparam int PTR_W   = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int COUNT_W = $clog2(DEPTH + 1);

	aads_pkg::op_t      slot_q [DEPTH];
	logic [PTR_W-1:0]   wr_ptr_q;
	logic [PTR_W-1:0]   rd_ptr_q;
	logic [COUNT_W-1:0] count_q;
	logic               push;
	logic               pop;

	assign in_ready  = (count_q != COUNT_W'(DEPTH));
	assign out_valid = (count_q != '0);
	assign out_op    = slot_q[rd_ptr_q];
	assign push      = in_valid && in_ready;
	assign pop       = out_valid && out_ready;

	function automatic logic [PTR_W-1:0] ptr_next(input logic [PTR_W-1:0] p);
		if (p == PTR_W'(DEPTH - 1)) begin
			return '0;
		end
		return p + 1'b1;
	endfunction

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= ptr_next(wr_ptr_q);
			end
			if (pop) begin
				rd_ptr_q <= ptr_next(rd_ptr_q);
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			slot_q[wr_ptr_q] <= in_op;
		end
	end

endmodule

`default_nettype wire

// ===== rtl/aads_back.sv =====
// ----------------------------------------------------------------------------
// aads_back
// Executes classified items on the alarm state and holds the result beat.
// ----------------------------------------------------------------------------
`default_nettype none

module aads_back #(
	parameter int TIME_WIDTH = aads_pkg::TIME_WIDTH_DEFAULT
) (
	input  wire                         clk,
	input  wire                         arst_n,
	input  wire                         op_valid,
	output logic                        op_ready,
	input  aads_pkg::op_t               op,
	input  wire                         cfg_wr_en,
	input  wire [aads_pkg::IDX_W-1:0]   cfg_index,
	input  wire [aads_pkg::REG_W-1:0]   cfg_wdata,
	output logic                        res_valid,
	input  wire                         res_ready,
	output logic                        res_buzzer_on,
	output logic                        res_alarm_active,
	output logic                        res_is_silenced,
	output logic [aads_pkg::KIND_W-1:0] res_alarm_kind
);

	localparam int CMP_W = (TIME_WIDTH > aads_pkg::REG_W) ? TIME_WIDTH : aads_pkg::REG_W;

	logic [aads_pkg::REG_W-1:0]  delay_q;
	logic [aads_pkg::REG_W-1:0]  crit_toggle_q;
	logic [aads_pkg::REG_W-1:0]  warn_toggle_q;

	logic                        alarm_q, alarm_n;
	logic                        sil_q, sil_n;
	logic                        tone_q, tone_n;
	logic [aads_pkg::KIND_W-1:0] kind_q, kind_n;
	logic [aads_pkg::CAT_W-1:0]  prev_q, prev_n;
	logic [TIME_WIDTH-1:0]       since_chg_q, since_chg_n, since_chg_inc;
	logic [TIME_WIDTH-1:0]       since_tgl_q, since_tgl_n, since_tgl_inc;
	logic [aads_pkg::REG_W-1:0]  interval;
	logic                        want;
	logic                        res_valid_q;
	logic                        pop;

	assign op_ready = !res_valid_q || res_ready;
	assign pop      = op_valid && op_ready;

	assign since_chg_inc = (&since_chg_q) ? since_chg_q : since_chg_q + 1'b1;
	assign since_tgl_inc = (&since_tgl_q) ? since_tgl_q : since_tgl_q + 1'b1;
	assign interval      = (kind_q == aads_pkg::KIND_CRITICAL) ? crit_toggle_q : warn_toggle_q;

	always_comb begin
		alarm_n     = alarm_q;
		sil_n       = sil_q;
		tone_n      = tone_q;
		kind_n      = kind_q;
		prev_n      = prev_q;
		since_chg_n = since_chg_q;
		since_tgl_n = since_tgl_q;
		want        = 1'b0;
		unique case (op.kind)
			aads_pkg::OP_TICK: begin
				since_chg_n = since_chg_inc;
				since_tgl_n = since_tgl_inc;
				if (alarm_q && !sil_q) begin
					if (CMP_W'(since_tgl_inc) >= CMP_W'(interval)) begin
						since_tgl_n = '0;
						tone_n      = !tone_q;
					end
				end else begin
					tone_n = 1'b0;
				end
			end
			aads_pkg::OP_UPDATE: begin
				if (op.category != prev_q) begin
					since_chg_n = '0;
					// entering an alert category from normal rearms the buzzer
					if (op.cat_nonzero && prev_q == aads_pkg::CAT_NORMAL) begin
						sil_n = 1'b0;
					end
					prev_n = op.category;
				end
				want = op.cat_crit ||
					(op.cat_warn && CMP_W'(since_chg_n) >= CMP_W'(delay_q));
				if (!op.cat_warn && !op.cat_crit && alarm_q) begin
					sil_n = 1'b0;
				end
				if (want != alarm_q) begin
					alarm_n = want;
					kind_n  = op.kind_code;
					if (!(want && !sil_n)) begin
						tone_n = 1'b0;
					end
				end
			end
			aads_pkg::OP_SILENCE: begin
				if (alarm_q) begin
					sil_n  = 1'b1;
					tone_n = 1'b0;
				end
			end
			aads_pkg::OP_NONE: begin
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			alarm_q     <= 1'b0;
			sil_q       <= 1'b0;
			tone_q      <= 1'b0;
			kind_q      <= aads_pkg::KIND_NONE;
			prev_q      <= aads_pkg::CAT_NORMAL;
			since_chg_q <= '0;
			since_tgl_q <= '0;
			res_valid_q <= 1'b0;
		end else begin
			res_valid_q <= pop || (res_valid_q && !res_ready);
			// state doubles as the result payload: it moves only with a new beat
			if (pop) begin
				alarm_q     <= alarm_n;
				sil_q       <= sil_n;
				tone_q      <= tone_n;
				kind_q      <= kind_n;
				prev_q      <= prev_n;
				since_chg_q <= since_chg_n;
				since_tgl_q <= since_tgl_n;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			delay_q       <= aads_pkg::WARNING_DELAY_RST;
			crit_toggle_q <= aads_pkg::CRITICAL_TOGGLE_RST;
			warn_toggle_q <= aads_pkg::WARNING_TOGGLE_RST;
		end else if (cfg_wr_en) begin
			unique case (cfg_index)
				aads_pkg::REG_WARNING_DELAY:   delay_q       <= cfg_wdata;
				aads_pkg::REG_CRITICAL_TOGGLE: crit_toggle_q <= cfg_wdata;
				aads_pkg::REG_WARNING_TOGGLE:  warn_toggle_q <= cfg_wdata;
				default: begin
				end
			endcase
		end
	end

	assign res_valid        = res_valid_q;
	assign res_buzzer_on    = tone_q;
	assign res_alarm_active = alarm_q;
	assign res_is_silenced  = sil_q;
	assign res_alarm_kind   = kind_q;

endmodule

`default_nettype wire

// ===== rtl/aads_checker.sv =====
// ----------------------------------------------------------------------------
// aads_checker
// Port-level checks of the annunciator, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

`include "alarm_annunciator_with_delay_and_silence_core_assert.svh"

module aads_checker (
	input wire                        clk,
	input wire                        arst_n,
	input wire                        res_valid,
	input wire                        res_ready,
	input wire                        buzzer_on,
	input wire                        alarm_active,
	input wire                        is_silenced,
	input wire [aads_pkg::KIND_W-1:0] alarm_kind
);

	`AADS_ASSERT_NOW(a_buzzer_needs_live_alarm, res_valid && buzzer_on, alarm_active && !is_silenced, "buzzer on without a live unsilenced alarm")

	`AADS_ASSERT_NOW(a_raised_has_kind, res_valid && alarm_active, alarm_kind != aads_pkg::KIND_NONE, "alarm raised with no recorded kind")

	`AADS_ASSERT_NEXT(a_stalled_beat_holds, res_valid && !res_ready, res_valid && $stable(buzzer_on) && $stable(alarm_active) && $stable(is_silenced) && $stable(alarm_kind), "stalled result beat changed")

endmodule

bind alarm_annunciator_with_delay_and_silence_core aads_checker u_aads_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.res_valid    (res.valid),
	.res_ready    (res.ready),
	.buzzer_on    (res.buzzer_on),
	.alarm_active (res.alarm_active),
	.is_silenced  (res.is_silenced),
	.alarm_kind   (res.alarm_kind)
);

`default_nettype wire

// ===== tb/alarm_annunciator_with_delay_and_silence_core_test.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// alarm_annunciator_with_delay_and_silence_core_test
// Self-checking bench for the alarm annunciator. Commands go in on the cmd
// channel with random gaps and the status beats are taken with random stalls.
// A model of the annunciator kept in the bench predicts every beat, and each
// beat is compared field by field in order. Directed cases cover the reset
// setting, zero delay and a zero critical interval, then random traffic runs under several
// register settings, the extremes among them.
// ----------------------------------------------------------------------------

module alarm_annunciator_with_delay_and_silence_core_test;

	localparam int TIME_WIDTH = aads_pkg::TIME_WIDTH_DEFAULT;

	typedef logic [aads_pkg::CMD_W-1:0]  cmd_t;
	typedef logic [aads_pkg::CAT_W-1:0]  cat_t;
	typedef logic [aads_pkg::KIND_W-1:0] kind_t;
	typedef logic [aads_pkg::REG_W-1:0]  regv_t;
	typedef logic [aads_pkg::IDX_W-1:0]  idx_t;
	typedef logic [TIME_WIDTH-1:0]       ms_t;

	localparam ms_t TIME_MAX = '1;
	localparam regv_t REG_MAX = '1;
	localparam cmd_t CMD_UNUSED = 2'd3;
	localparam idx_t REG_UNUSED = 2'd3;
	localparam int GAP_MAX = 18;
	localparam int QUIET_LIMIT = 4000;
	localparam int SETTLE_CYCLES = 8;
	localparam int PHASE_ITEMS = 205;

	typedef struct packed {
		logic  buzzer;
		logic  alarm;
		logic  silenced;
		kind_t kind;
	} status_t;

	logic clk = 1'b0;
	logic arst_n;
	logic cfg_wr_en;
	idx_t cfg_index;
	regv_t cfg_wdata;

	aads_cmd_if cmd_bus ();
	aads_res_if res_bus ();

	alarm_annunciator_with_delay_and_silence_core #(
		.TIME_WIDTH(TIME_WIDTH)
	) u_dut (
		.clk(clk),
		.arst_n(arst_n),
		.cmd(cmd_bus),
		.res(res_bus),
		.cfg_wr_en(cfg_wr_en),
		.cfg_index(cfg_index),
		.cfg_wdata(cfg_wdata)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// Annunciator state as the bench sees it
	regv_t warn_delay;
	regv_t crit_interval;
	regv_t warn_interval;
	logic alarm_on;
	logic silence_latched;
	kind_t kind_held;
	cat_t last_category;
	ms_t ms_since_change;
	ms_t ms_since_toggle;
	logic tone_on;

	status_t status_q[$];
	int mismatches = 0;
	int beats_checked = 0;
	int cmd_count[4] = '{0, 0, 0, 0};
	int raise_count = 0;
	int flip_count = 0;
	int silence_count = 0;
	int setting_count = 0;
	int quiet_cycles = 0;
	int src_run = 0;
	bit src_idle = 1'b0;

	function automatic ms_t sat_step(input ms_t v);
		return (v == TIME_MAX) ? TIME_MAX : v + 1'b1;
	endfunction

	function automatic status_t advance_annunciator(input cmd_t c, input cat_t cat);
		logic want;
		regv_t interval;
		want = 1'b0;
		unique case (c)
			aads_pkg::CMD_TICK: begin
				ms_since_change = sat_step(ms_since_change);
				ms_since_toggle = sat_step(ms_since_toggle);
				if (alarm_on && !silence_latched) begin
					interval = (kind_held == aads_pkg::KIND_CRITICAL) ?
						crit_interval : warn_interval;
					if (ms_since_toggle >= interval) begin
						ms_since_toggle = '0;
						tone_on = !tone_on;
						flip_count++;
					end
				end else begin
					tone_on = 1'b0;
				end
			end
			aads_pkg::CMD_UPDATE: begin
				if (cat != last_category) begin
					ms_since_change = '0;
					if (cat != aads_pkg::CAT_NORMAL && last_category == aads_pkg::CAT_NORMAL)
						silence_latched = 1'b0;
					last_category = cat;
				end
				if (cat == aads_pkg::CAT_CRITICAL)
					want = 1'b1;
				else if (cat == aads_pkg::CAT_WARNING)
					want = (ms_since_change >= warn_delay);
				else if (alarm_on)
					silence_latched = 1'b0;
				if (want != alarm_on) begin
					alarm_on = want;
					if (want)
						raise_count++;
					if (cat == aads_pkg::CAT_WARNING)
						kind_held = aads_pkg::KIND_WARNING;
					else if (cat == aads_pkg::CAT_CRITICAL)
						kind_held = aads_pkg::KIND_CRITICAL;
					else
						kind_held = aads_pkg::KIND_NONE;
					if (!(want && !silence_latched))
						tone_on = 1'b0;
				end
			end
			aads_pkg::CMD_SILENCE: begin
				if (alarm_on) begin
					silence_latched = 1'b1;
					tone_on = 1'b0;
					silence_count++;
				end
			end
			default: begin
			end
		endcase
		return '{buzzer: tone_on, alarm: alarm_on, silenced: silence_latched, kind: kind_held};
	endfunction

	task automatic report_mismatch(input string what, input int expv, input int actv);
		mismatches++;
		if (mismatches <= 10)
			$display("%0t mismatch on %s: expected %0d, got %0d", $realtime, what, expv, actv);
	endtask

	// Check every status beat against the oldest prediction
	always @(posedge clk) begin
		status_t want_beat;
		if (arst_n === 1'b1 && res_bus.valid === 1'b1 && res_bus.ready === 1'b1) begin
			beats_checked++;
			if (status_q.size() == 0) begin
				report_mismatch("unexpected status beat", 0, 1);
			end else begin
				want_beat = status_q.pop_front();
				if (res_bus.buzzer_on !== want_beat.buzzer)
					report_mismatch("buzzer_on", int'(want_beat.buzzer),
						int'(res_bus.buzzer_on));
				if (res_bus.alarm_active !== want_beat.alarm)
					report_mismatch("alarm_active", int'(want_beat.alarm),
						int'(res_bus.alarm_active));
				if (res_bus.is_silenced !== want_beat.silenced)
					report_mismatch("is_silenced", int'(want_beat.silenced),
						int'(res_bus.is_silenced));
				if (res_bus.alarm_kind !== want_beat.kind)
					report_mismatch("alarm_kind", int'(want_beat.kind),
						int'(res_bus.alarm_kind));
			end
		end
	end

	always @(posedge clk) begin
		if (arst_n === 1'b1) begin
			if ((cmd_bus.valid && cmd_bus.ready) || (res_bus.valid && res_bus.ready))
				quiet_cycles = 0;
			else
				quiet_cycles++;
			if (quiet_cycles >= QUIET_LIMIT) begin
				$display("timeout: no beat for %0d cycles, %0d status beats outstanding",
					QUIET_LIMIT, status_q.size());
				$display("FAIL");
				$finish;
			end
		end
	end

	// Take status beats with random stalls, in stretches with and without them
	initial begin : status_sink
		int stall;
		int snk_run;
		bit snk_idle;
		snk_run = 0;
		snk_idle = 1'b0;
		res_bus.ready = 1'b0;
		wait (arst_n === 1'b1);
		forever begin
			if (snk_run == 0) begin
				snk_idle = ($urandom_range(0, 3) != 0);
				snk_run = $urandom_range(10, 60);
			end
			snk_run--;
			stall = snk_idle ? $urandom_range(0, GAP_MAX) : 0;
			if (stall > 0) begin
				res_bus.ready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			res_bus.ready <= 1'b1;
			@(posedge clk);
			while (res_bus.valid !== 1'b1) @(posedge clk);
		end
	end

	// Valid stays high after a beat; the next gap or a drain drops it
	task automatic send_item(input cmd_t c, input cat_t cat);
		int gap;
		if (src_run == 0) begin
			src_idle = ($urandom_range(0, 3) != 0);
			src_run = $urandom_range(10, 60);
		end
		src_run--;
		gap = src_idle ? $urandom_range(0, GAP_MAX) : 0;
		if (gap > 0) begin
			cmd_bus.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		cmd_bus.valid <= 1'b1;
		cmd_bus.command <= c;
		cmd_bus.category <= cat;
		@(posedge clk);
		while (cmd_bus.ready !== 1'b1) @(posedge clk);
		cmd_count[c]++;
		status_q.push_back(advance_annunciator(c, cat));
	endtask

	task automatic drain();
		cmd_bus.valid <= 1'b0;
		while (status_q.size() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// Write enable stays high across back-to-back writes; write_config drops it
	task automatic write_reg(input idx_t idx, input regv_t data);
		cfg_wr_en <= 1'b1;
		cfg_index <= idx;
		cfg_wdata <= data;
		@(posedge clk);
		unique case (idx)
			aads_pkg::REG_WARNING_DELAY:   warn_delay = data;
			aads_pkg::REG_CRITICAL_TOGGLE: crit_interval = data;
			aads_pkg::REG_WARNING_TOGGLE:  warn_interval = data;
			default: begin
			end
		endcase
	endtask

	task automatic write_config(input regv_t delay, input regv_t crit, input regv_t warn);
		drain();
		write_reg(aads_pkg::REG_WARNING_DELAY, delay);
		write_reg(aads_pkg::REG_CRITICAL_TOGGLE, crit);
		write_reg(aads_pkg::REG_WARNING_TOGGLE, warn);
		// index 3 holds no register and must change nothing
		write_reg(REG_UNUSED, regv_t'($urandom()));
		cfg_wr_en <= 1'b0;
		@(posedge clk);
		setting_count++;
	endtask

	// Reset setting: critical raise, silence, critical to warning keeps the latch
	task automatic test_reset_defaults();
		send_item(aads_pkg::CMD_TICK, aads_pkg::CAT_NORMAL);
		send_item(aads_pkg::CMD_SILENCE, aads_pkg::CAT_NORMAL);
		send_item(CMD_UNUSED, 8'd255);
		send_item(aads_pkg::CMD_UPDATE, aads_pkg::CAT_CRITICAL);
		send_item(aads_pkg::CMD_TICK, 8'd170);
		send_item(aads_pkg::CMD_SILENCE, 8'd85);
		send_item(aads_pkg::CMD_TICK, aads_pkg::CAT_NORMAL);
		send_item(aads_pkg::CMD_UPDATE, aads_pkg::CAT_WARNING);
		send_item(aads_pkg::CMD_UPDATE, aads_pkg::CAT_NORMAL);
		send_item(aads_pkg::CMD_UPDATE, aads_pkg::CAT_CRITICAL);
		send_item(aads_pkg::CMD_UPDATE, 8'd255);
		send_item(aads_pkg::CMD_UPDATE, 8'd128);
		send_item(aads_pkg::CMD_UPDATE, aads_pkg::CAT_NORMAL);
		drain();
	endtask

	// Zero delay raises a warning on its first update; zero interval flips every tick
	task automatic test_zero_delay();
		write_config('0, '0, 24'd1);
		send_item(aads_pkg::CMD_UPDATE, aads_pkg::CAT_WARNING);
		send_item(aads_pkg::CMD_TICK, aads_pkg::CAT_NORMAL);
		send_item(aads_pkg::CMD_TICK, aads_pkg::CAT_NORMAL);
		send_item(aads_pkg::CMD_UPDATE, aads_pkg::CAT_CRITICAL);
		send_item(aads_pkg::CMD_TICK, aads_pkg::CAT_NORMAL);
		send_item(aads_pkg::CMD_TICK, aads_pkg::CAT_NORMAL);
		send_item(aads_pkg::CMD_SILENCE, aads_pkg::CAT_NORMAL);
		send_item(aads_pkg::CMD_TICK, aads_pkg::CAT_NORMAL);
		send_item(aads_pkg::CMD_UPDATE, aads_pkg::CAT_NORMAL);
		send_item(aads_pkg::CMD_UPDATE, aads_pkg::CAT_CRITICAL);
		send_item(aads_pkg::CMD_TICK, aads_pkg::CAT_NORMAL);
		send_item(aads_pkg::CMD_TICK, aads_pkg::CAT_NORMAL);
		send_item(aads_pkg::CMD_UPDATE, 8'd3);
		drain();
	endtask

	// Categories persist across several updates so warnings can outlast the delay
	task automatic run_random_phase(input regv_t delay, input regv_t crit, input regv_t warn);
		cmd_t c;
		cat_t cat;
		cat_t level;
		int pick;
		write_config(delay, crit, warn);
		level = aads_pkg::CAT_NORMAL;
		for (int i = 0; i < PHASE_ITEMS; i++) begin
			// hold off until every outstanding status beat is back
			if (i == PHASE_ITEMS / 2)
				drain();
			pick = $urandom_range(0, 99);
			cat = aads_pkg::CAT_NORMAL;
			if (pick < 55) begin
				c = aads_pkg::CMD_TICK;
			end else if (pick < 87) begin
				c = aads_pkg::CMD_UPDATE;
				pick = $urandom_range(0, 99);
				if (pick < 12)
					level = cat_t'($urandom_range(0, 2));
				else if (pick < 16)
					level = cat_t'($urandom_range(0, 255));
				cat = level;
			end else if (pick < 96) begin
				c = aads_pkg::CMD_SILENCE;
			end else begin
				c = CMD_UNUSED;
			end
			if (c != aads_pkg::CMD_UPDATE && $urandom_range(0, 3) == 0)
				cat = cat_t'($urandom_range(0, 255));
			send_item(c, cat);
		end
		drain();
	endtask

	task automatic test_random_mix();
		run_random_phase(24'd5, 24'd2, 24'd3);
		run_random_phase('0, 24'd1, 24'd1);
		run_random_phase(24'd8, 24'd4, 24'd7);
		run_random_phase(REG_MAX, REG_MAX, REG_MAX);
		run_random_phase(regv_t'($urandom_range(0, 15)), regv_t'($urandom_range(1, 8)),
			regv_t'($urandom_range(1, 8)));
		run_random_phase(24'd3, '0, '0);
	endtask

	initial begin
		arst_n = 1'b0;
		cfg_wr_en = 1'b0;
		cfg_index = aads_pkg::REG_WARNING_DELAY;
		cfg_wdata = '0;
		cmd_bus.valid = 1'b0;
		cmd_bus.command = aads_pkg::CMD_TICK;
		cmd_bus.category = aads_pkg::CAT_NORMAL;
		warn_delay = aads_pkg::WARNING_DELAY_RST;
		crit_interval = aads_pkg::CRITICAL_TOGGLE_RST;
		warn_interval = aads_pkg::WARNING_TOGGLE_RST;
		alarm_on = 1'b0;
		silence_latched = 1'b0;
		kind_held = aads_pkg::KIND_NONE;
		last_category = aads_pkg::CAT_NORMAL;
		ms_since_change = '0;
		ms_since_toggle = '0;
		tone_on = 1'b0;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_reset_defaults();
		test_zero_delay();
		test_random_mix();
		drain();

		$display("covered %0d ticks, %0d updates, %0d silences, %0d unused commands, %0d settings",
			cmd_count[aads_pkg::CMD_TICK], cmd_count[aads_pkg::CMD_UPDATE],
			cmd_count[aads_pkg::CMD_SILENCE], cmd_count[CMD_UNUSED], setting_count);
		$display("alarm raised %0d times, buzzer toggled %0d times, silenced %0d times, %0d beats",
			raise_count, flip_count, silence_count, beats_checked);
		if (mismatches == 0 && status_q.size() == 0) begin
			$display("PASS");
		end else begin
			$display("%0d mismatches, %0d status beats outstanding", mismatches, status_q.size());
			$display("FAIL");
		end
		$finish;
	end

endmodule
